// ===== hdl/dmcc_pkg.sv =====
// Shared types and constants for the debounced multi-click classifier.
`default_nettype none
package dmcc_pkg;

  localparam int unsigned TickW     = 17;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CountW    = 8;
  localparam int unsigned ClassW    = 3;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 16;

  localparam logic [TickW-1:0]  TickMax  = {TickW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam int unsigned MaxClickClass = 5;
  localparam int unsigned ClassFieldMax = (1 << ClassW) - 1;
  localparam logic [CountW-1:0] ClassLimit =
      CountW'((MaxClickClass > ClassFieldMax) ? ClassFieldMax : MaxClickClass);

  localparam logic [CfgW-1:0] DebounceReset = CfgW'(30);
  localparam logic [CfgW-1:0] TimeoutReset  = CfgW'(400);

  typedef enum logic [0:0] {
    CfgDebounce = 1'b0,
    CfgTimeout  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [CountW-1:0] pending_clicks;
    logic [ClassW-1:0] click_class;
    logic              stable_level;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage
`default_nettype wire

// ===== hdl/debounced_multi_click_classifier.sv =====
// Top level of the debounced multi-click classifier.
// One input transaction is one tick carrying the raw button level in bit 0 of
// s_axis_tdata; every tick yields exactly one output transaction with the
// debounced level, the class of a click group that ended on that tick (0 when
// none, else min(clicks, 5)) and the clicks pending in the open group. The
// block takes one tick per cycle while the output buffer is not full: the state
// update is a single pass of counter and compare logic, and a two-entry output
// buffer keeps the input open while one result waits for the consumer.
// Registers, written through cfg_we_i/cfg_idx_i/cfg_data_i: index 0 is the
// debounce time in ticks (reset 30), index 1 the click group timeout in ticks
// (reset 400). Write them only while no transaction is in flight.
`default_nettype none
module debounced_multi_click_classifier (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [0:0]                     cfg_idx_i,
  input  wire logic [dmcc_pkg::CfgW-1:0]      cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] button_sample, [7:1] zero
  input  wire logic [dmcc_pkg::InTdataW-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [0] stable_level, [3:1] click_class, [11:4] pending_clicks, [15:12] zero
  output logic [dmcc_pkg::OutTdataW-1:0]      m_axis_tdata
);

  dmcc_pkg::result_t core_result, out_result;
  logic              push;

  assign push = s_axis_tvalid && s_axis_tready;

  dmcc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .sample_i   (s_axis_tdata[0]),
    .result_o   (core_result)
  );

  dmcc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (core_result),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (out_result)
  );

  assign m_axis_tdata = {{(dmcc_pkg::OutTdataW - dmcc_pkg::ResultW){1'b0}}, out_result};

endmodule
`default_nettype wire

// ===== hdl/dmcc_core.sv =====
// Per-tick debounce, click counting and group classification with its state registers.
`default_nettype none
module dmcc_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [0:0]                cfg_idx_i,
  input  wire logic [dmcc_pkg::CfgW-1:0] cfg_data_i,
  input  wire logic                      push_i,
  input  wire logic                      sample_i,
  output dmcc_pkg::result_t              result_o
);

  logic [dmcc_pkg::CfgW-1:0]   debounce_q, timeout_q;
  logic                        prev_q, prev_d;
  logic                        level_q, level_d;
  logic [dmcc_pkg::TickW-1:0]  change_q, change_d;
  logic [dmcc_pkg::TickW-1:0]  since_q, since_d, since_inc;
  logic [dmcc_pkg::CountW-1:0] count_q, count_d, count_upd;
  logic                        fire, rise, emit;
  logic [dmcc_pkg::ClassW-1:0] cls;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= dmcc_pkg::DebounceReset;
      timeout_q  <= dmcc_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (dmcc_pkg::cfg_idx_e'(cfg_idx_i))
        dmcc_pkg::CfgDebounce: debounce_q <= cfg_data_i;
        dmcc_pkg::CfgTimeout:  timeout_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    prev_d = sample_i;
    if (sample_i != prev_q) begin
      change_d = '0;
    end else begin
      change_d = (change_q == dmcc_pkg::TickMax) ? change_q : change_q + 1'b1;
    end
    since_inc = (since_q == dmcc_pkg::TickMax) ? since_q : since_q + 1'b1;

    fire    = (change_d > {1'b0, debounce_q}) && (sample_i != level_q);
    rise    = fire && sample_i;
    level_d = fire ? sample_i : level_q;

    count_upd = count_q;
    since_d   = since_inc;
    if (rise) begin
      count_upd = (count_q == dmcc_pkg::CountMax) ? count_q : count_q + 1'b1;
      since_d   = '0;
    end

    emit    = (count_upd != '0) && (since_d > {1'b0, timeout_q});
    cls     = '0;
    count_d = count_upd;
    if (emit) begin
      cls = (count_upd > dmcc_pkg::ClassLimit) ? dmcc_pkg::ClassLimit[dmcc_pkg::ClassW-1:0]
                                               : count_upd[dmcc_pkg::ClassW-1:0];
      count_d = '0;
    end

    result_o.stable_level   = level_d;
    result_o.click_class    = cls;
    result_o.pending_clicks = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      level_q  <= 1'b0;
      change_q <= '0;
      since_q  <= '0;
      count_q  <= '0;
    end else if (push_i) begin
      prev_q   <= prev_d;
      level_q  <= level_d;
      change_q <= change_d;
      since_q  <= since_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.click_class != '0) |-> (result_o.pending_clicks == '0))
    else $error("emitted class with clicks still pending");
  a_class_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({5'b0, result_o.click_class} <= dmcc_pkg::ClassLimit))
    else $error("click class above limit");
  a_click_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && rise) |=> (since_q == '0))
    else $error("click did not restart the timeout counter");
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_i |=> ($stable(count_q) && $stable(level_q)))
    else $error("state changed without a transaction");
`endif

endmodule
`default_nettype wire

// ===== hdl/dmcc_out_buf.sv =====
// Two-entry result buffer between the core and the output stream.
`default_nettype none
module dmcc_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire dmcc_pkg::result_t data_i,
  output logic                   ready_o,
  output logic                   valid_o,
  input  wire logic              pop_ready_i,
  output dmcc_pkg::result_t      data_o
);

  dmcc_pkg::result_t main_q, skid_q;
  logic              main_valid_q, skid_valid_q;
  logic              pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;
  assign pop     = main_valid_q && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (push_i && pop) begin
        main_valid_q <= 1'b1;
      end else if (push_i) begin
        if (main_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          main_valid_q <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          main_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && (pop || !main_valid_q)) begin
      main_q <= data_i;
    end else if (pop && skid_valid_q) begin
      main_q <= skid_q;
    end
    if (push_i && main_valid_q && !pop) begin
      skid_q <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held without main entry");
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && pop) |=> (main_q == $past(skid_q)))
    else $error("skid entry not moved to output");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("transaction taken while buffer full");
`endif

endmodule
`default_nettype wire
